FILE: design/clipped_rect_outline_drawer_assert.svh
// assertion macros used by the checker file of the outline drawer
`ifndef CLIPPED_RECT_OUTLINE_DRAWER_ASSERT_SVH
`define CLIPPED_RECT_OUTLINE_DRAWER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define CROD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define CROD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

FILE: design/crod_pkg.sv
// shared types and constants of the clipped rectangle outline drawer
`default_nettype none

package crod_pkg;

  localparam int COORD_W = 12;
  localparam int COLOR_W = 16;
  localparam int ADDR_W  = 17;
  localparam int COL_W   = 9;
  localparam int ROW_W   = 8;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HORZ = 2'd1,
    PH_VERT = 2'd2
  } phase_t;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_STEP  = 1'b1
  } func_t;

  typedef struct packed {
    logic                       func;
    logic signed [COORD_W-1:0]  rect_left;
    logic signed [COORD_W-1:0]  rect_top;
    logic signed [COORD_W-1:0]  rect_width;
    logic signed [COORD_W-1:0]  rect_height;
    logic        [COLOR_W-1:0]  pixel_color;
  } item_t;

  typedef struct packed {
    logic               write_valid;
    logic [ADDR_W-1:0]  pixel_address;
    logic [COLOR_W-1:0] write_color;
    logic               done_res;
  } result_t;

endpackage

`default_nettype wire

FILE: design/crod_core.sv
// outline walker: rectangle setup, clipping, edge state and pixel address
`default_nettype none

module crod_core import crod_pkg::*; #(
  parameter int SCREEN_W = 320,
  parameter int SCREEN_H = 240
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    fire,
  input  wire item_t   item,
  output result_t      result
);

  localparam logic signed [13:0] SW_S   = 14'(SCREEN_W);
  localparam logic signed [13:0] SH_S   = 14'(SCREEN_H);
  localparam logic [ADDR_W-1:0]  SW_MUL = ADDR_W'(SCREEN_W);

  phase_t             phase, phase_next;
  logic               alt, alt_next;
  logic [COL_W-1:0]   col_counter, col_counter_next;
  logic [COL_W-1:0]   col_limit, col_limit_next;
  logic [ROW_W-1:0]   row_counter, row_counter_next;
  logic [ROW_W-1:0]   row_limit, row_limit_next;
  logic [ROW_W-1:0]   top_row, top_row_next, bot_row, bot_row_next;
  logic [COL_W-1:0]   left_col, left_col_next, right_col, right_col_next;
  logic [3:0]         edge_en, edge_en_next;
  logic [COLOR_W-1:0] held_color, held_color_next;

  logic signed [13:0] left_s, top_s, right_s, bottom_s;
  logic signed [13:0] c0, c1, r0, r1;
  logic [3:0]         start_en;
  logic               h_first, v_first, h_second, v_second;
  logic               h_last, v_last;
  logic [ROW_W-1:0]   h_row;
  logic [COL_W-1:0]   v_col;

  // setup arithmetic for a start word
  always_comb begin
    left_s   = 14'(item.rect_left);
    top_s    = 14'(item.rect_top);
    right_s  = left_s + 14'(item.rect_width);
    bottom_s = top_s + 14'(item.rect_height);
    c0 = (left_s < 0) ? 14'sd0 : left_s;
    c1 = (right_s > SW_S) ? SW_S : right_s;
    r0 = (top_s < 0) ? 14'sd0 : top_s;
    r1 = (bottom_s > SH_S) ? SH_S : bottom_s;
    start_en[0] = (c0 < c1) && (top_s >= 0) && (top_s < SH_S);
    start_en[1] = (c0 < c1) && (bottom_s >= 0) && (bottom_s < SH_S);
    start_en[2] = (r0 < r1) && (left_s >= 0) && (left_s < SW_S);
    start_en[3] = (r0 < r1) && (right_s >= 0) && (right_s < SW_S);
  end

  // edge selection while stepping
  always_comb begin
    h_first  = !alt && edge_en[0];
    h_row    = h_first ? top_row : bot_row;
    h_second = h_first && edge_en[1];
    h_last   = !h_second && (col_counter >= col_limit);
    v_first  = !alt && edge_en[2];
    v_col    = v_first ? left_col : right_col;
    v_second = v_first && edge_en[3];
    v_last   = !v_second && (row_counter >= row_limit);
  end

  // next phase
  always_comb begin
    phase_next = phase;
    if (item.func == FUNC_START) begin
      if (start_en[1:0] != 2'b00) begin
        phase_next = PH_HORZ;
      end else if (start_en[3:2] != 2'b00) begin
        phase_next = PH_VERT;
      end else begin
        phase_next = PH_IDLE;
      end
    end else begin
      case (phase)
        PH_HORZ: begin
          if (h_last) begin
            phase_next = (edge_en[3:2] != 2'b00) ? PH_VERT : PH_IDLE;
          end
        end
        PH_VERT: begin
          if (v_last) begin
            phase_next = PH_IDLE;
          end
        end
        default: phase_next = phase;
      endcase
    end
  end

  // datapath updates and result word
  always_comb begin
    alt_next         = alt;
    col_counter_next = col_counter;
    col_limit_next   = col_limit;
    row_counter_next = row_counter;
    row_limit_next   = row_limit;
    top_row_next     = top_row;
    bot_row_next     = bot_row;
    left_col_next    = left_col;
    right_col_next   = right_col;
    edge_en_next     = edge_en;
    held_color_next  = held_color;
    result.write_valid   = 1'b0;
    result.pixel_address = '0;
    result.write_color   = '0;
    if (item.func == FUNC_START) begin
      alt_next         = 1'b0;
      col_counter_next = c0[COL_W-1:0];
      col_limit_next   = COL_W'(c1 - 14'sd1);
      row_counter_next = r0[ROW_W-1:0];
      row_limit_next   = ROW_W'(r1 - 14'sd1);
      top_row_next     = top_s[ROW_W-1:0];
      bot_row_next     = bottom_s[ROW_W-1:0];
      left_col_next    = left_s[COL_W-1:0];
      right_col_next   = right_s[COL_W-1:0];
      edge_en_next     = start_en;
      held_color_next  = item.pixel_color;
    end else begin
      case (phase)
        PH_HORZ: begin
          result.write_valid   = 1'b1;
          result.pixel_address = ADDR_W'(ADDR_W'(h_row) * SW_MUL)
                               + ADDR_W'(col_counter);
          result.write_color   = held_color;
          alt_next = h_second;
          if (!h_second && !h_last) begin
            col_counter_next = col_counter + COL_W'(1);
          end
        end
        PH_VERT: begin
          result.write_valid   = 1'b1;
          result.pixel_address = ADDR_W'(ADDR_W'(row_counter) * SW_MUL)
                               + ADDR_W'(v_col);
          result.write_color   = held_color;
          alt_next = v_second;
          if (!v_second && !v_last) begin
            row_counter_next = row_counter + ROW_W'(1);
          end
        end
        default: alt_next = alt;
      endcase
    end
    result.done_res = (phase_next != PH_HORZ) && (phase_next != PH_VERT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      alt   <= 1'b0;
    end else if (fire) begin
      phase <= phase_next;
      alt   <= alt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      col_counter <= col_counter_next;
      col_limit   <= col_limit_next;
      row_counter <= row_counter_next;
      row_limit   <= row_limit_next;
      top_row     <= top_row_next;
      bot_row     <= bot_row_next;
      left_col    <= left_col_next;
      right_col   <= right_col_next;
      edge_en     <= edge_en_next;
      held_color  <= held_color_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/clipped_rect_outline_drawer.sv
// top level of the clipped rectangle outline drawer
// A start word (func 0) loads a rectangle (signed left, top, width, height)
// and a color; each following step word (func 1) returns one framebuffer
// write of its outline until done, address row * SCREEN_W + column.
// Horizontal edges come first (top then bottom per column), then vertical
// edges (left then right per row), each edge clipped to the screen. Every
// input word gives exactly one result word; done_res marks the last pixel
// or a rectangle with nothing visible. The block takes one word per cycle
// while out_stall is low; a word passes one input register, then setup/step
// logic and the pixel address multiply-add in front of the result register.
`default_nettype none

module clipped_rect_outline_drawer import crod_pkg::*; #(
  parameter int SCREEN_W = 320,
  parameter int SCREEN_H = 240
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // input channel
  input  wire logic                      in_valid,
  output      logic                      in_stall,
  input  wire logic                      func,
  input  wire logic signed [COORD_W-1:0] rect_left,
  input  wire logic signed [COORD_W-1:0] rect_top,
  input  wire logic signed [COORD_W-1:0] rect_width,
  input  wire logic signed [COORD_W-1:0] rect_height,
  input  wire logic        [COLOR_W-1:0] pixel_color,
  // result channel
  output      logic                      out_valid,
  input  wire logic                      out_stall,
  output      logic                      write_valid,
  output      logic        [ADDR_W-1:0]  pixel_address,
  output      logic        [COLOR_W-1:0] write_color,
  output      logic                      done_res
);

  // input register
  logic    s1_valid;
  item_t   s1_item;
  // result register
  logic    o_valid;
  result_t o_res;

  logic    advance;
  logic    in_take;
  result_t core_res;

  // the staged word moves on when the result register is free or drains now
  assign advance  = s1_valid && (!o_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_take || (s1_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item.func        <= func;
      s1_item.rect_left   <= rect_left;
      s1_item.rect_top    <= rect_top;
      s1_item.rect_width  <= rect_width;
      s1_item.rect_height <= rect_height;
      s1_item.pixel_color <= pixel_color;
    end
  end

  // rectangle state and per-word pixel generation
  crod_core #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (s1_item),
    .result (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= 1'b1;
    end else if (!out_stall) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_res <= core_res;
    end
  end

  assign out_valid     = o_valid;
  assign write_valid   = o_res.write_valid;
  assign pixel_address = o_res.pixel_address;
  assign write_color   = o_res.write_color;
  assign done_res      = o_res.done_res;

endmodule

`default_nettype wire

FILE: design/crod_checker.sv
// port-level checks of the clipped rectangle outline drawer
`default_nettype none

`include "clipped_rect_outline_drawer_assert.svh"

module crod_checker import crod_pkg::*; #(
  parameter int SCREEN_W = 320,
  parameter int SCREEN_H = 240
) (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic               write_valid,
  input wire logic [ADDR_W-1:0]  pixel_address,
  input wire logic [COLOR_W-1:0] write_color
);

  // one bit wider than the address so a full 512 x 256 screen still fits
  localparam logic [ADDR_W:0] PIXELS = (ADDR_W+1)'(SCREEN_W * SCREEN_H);

  // a word without a write carries zero address and color
  `CROD_ASSERT_IMPL(a_nowrite_zero, out_valid && !write_valid, pixel_address == '0 && write_color == '0)
  // every write lands inside the framebuffer
  `CROD_ASSERT_IMPL(a_addr_in_range, out_valid && write_valid, {1'b0, pixel_address} < PIXELS)
  // a stalled result word holds
  `CROD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(pixel_address) && $stable(write_color))

endmodule

bind clipped_rect_outline_drawer crod_checker #(
  .SCREEN_W (SCREEN_W),
  .SCREEN_H (SCREEN_H)
) u_crod_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .write_valid   (write_valid),
  .pixel_address (pixel_address),
  .write_color   (write_color)
);

`default_nettype wire
